@@ src/nnrm_pkg.sv @@
// ----------------------------------------------------------------------------
// nnrm_pkg
// Shared types and constants of the nearest neighbor ratio match block.
// ----------------------------------------------------------------------------
package nnrm_pkg;

    localparam int DIST_W       = 38;
    localparam int TIDX_W       = 12;
    localparam int DIDX_W       = 6;
    localparam int FIELD_COMP_W = 16;
    localparam int QID_W        = 16;
    localparam int RATIO_W      = 16;
    localparam int TCOUNT_W     = 13;
    localparam int DIMS_W       = 7;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;
    localparam int RATIO_SHIFT  = 16;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIMS_IN_USE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RATIO_SQUARED = 2'd2;

    localparam logic [TCOUNT_W-1:0] TARGET_COUNT_RST  = 13'd1;
    localparam logic [DIMS_W-1:0]   DIMS_IN_USE_RST   = 7'd64;
    localparam logic [RATIO_W-1:0]  RATIO_SQUARED_RST = 16'd41943;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef struct packed {
        logic                           action;
        logic [TIDX_W-1:0]              target_index;
        logic [DIDX_W-1:0]              dim_index;
        logic signed [FIELD_COMP_W-1:0] component;
        logic [QID_W-1:0]               query_id;
        logic                           last;
    } in_item_t;

    typedef struct packed {
        logic [QID_W-1:0]  result_query_id;
        logic              matched;
        logic [TIDX_W-1:0] best_index;
        logic [DIST_W-1:0] nearest_distance;
        logic [DIST_W-1:0] runner_up_distance;
    } out_item_t;

    // position of a component read within its target descriptor
    typedef struct packed {
        logic first;
        logic last;
    } mac_tag_t;

endpackage

@@ src/nnrm_ram.sv @@
// ----------------------------------------------------------------------------
// nnrm_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module nnrm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ src/nnrm_dist.sv @@
// ----------------------------------------------------------------------------
// nnrm_dist
// Squared distance pipeline: absolute difference, square, saturating sum.
// ----------------------------------------------------------------------------
module nnrm_dist
    import nnrm_pkg::*;
#(
    parameter int COMP_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 mac_valid,
    input  mac_tag_t             mac_tag,
    input  logic [COMP_BITS-1:0] query_comp,
    input  logic [COMP_BITS-1:0] target_comp,
    output logic                 dist_valid,
    output logic [DIST_W-1:0]    distance
);

    localparam int MAG_W = COMP_BITS + 1;
    localparam int SQ_W  = 2 * MAG_W;
    localparam int SUM_W = ((SQ_W > DIST_W) ? SQ_W : DIST_W) + 1;

    logic signed [MAG_W-1:0] diff;
    logic [MAG_W-1:0]        mag_next;
    logic [MAG_W-1:0]        mag_reg;
    logic [SQ_W-1:0]         sq_next;
    logic [SQ_W-1:0]         sq_reg;
    logic [DIST_W-1:0]       base;
    logic [SUM_W-1:0]        sum;
    logic [DIST_W-1:0]       acc_next;
    logic [DIST_W-1:0]       acc_reg;
    mac_tag_t                tag1_reg;
    mac_tag_t                tag2_reg;
    logic                    v1_reg;
    logic                    v2_reg;
    logic                    dv_reg;

    assign diff     = MAG_W'(signed'(query_comp)) - MAG_W'(signed'(target_comp));
    assign mag_next = diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
    assign sq_next  = mag_reg * mag_reg;

    always_comb
    begin
        base = tag2_reg.first ? '0 : acc_reg;
        sum  = SUM_W'(base) + SUM_W'(sq_reg);
        if (sum > SUM_W'(DIST_MAX))
        begin
            acc_next = DIST_MAX;
        end
        else
        begin
            acc_next = DIST_W'(sum);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            dv_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= mac_valid;
            v2_reg <= v1_reg;
            dv_reg <= v2_reg && tag2_reg.last;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        tag1_reg <= mac_tag;
        sq_reg   <= sq_next;
        tag2_reg <= tag1_reg;
        if (v2_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    assign dist_valid = dv_reg;
    assign distance   = acc_reg;

endmodule

@@ src/nearest_neighbor_ratio_match.sv @@
// ----------------------------------------------------------------------------
// nearest_neighbor_ratio_match
// Brute force nearest neighbor search over stored descriptors with ratio test.
// ----------------------------------------------------------------------------
// Load transfers write one target component into the target RAM; query
// transfers write one component of the query descriptor. A query transfer
// marked last starts a search: the block walks targets 0 .. target_count-1
// and dimensions 0 .. dims_in_use-1 through one multiply-accumulate pipeline
// fed by the target RAM and query RAM read ports, one component pair per
// cycle. Input is stalled during the search and while a finished search
// waits for the output register to free up; loads and query components are
// otherwise taken every cycle, also while a result still waits at the output.
// Both RAMs are undefined after reset and need no clearing: every entry read
// by a search must be written first. Configuration must be written only while
// no search is in progress; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module nearest_neighbor_ratio_match
    import nnrm_pkg::*;
#(
    parameter int MAX_TARGETS = 4096,
    parameter int MAX_DIMS    = 64,
    parameter int COMP_BITS   = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_item_t             out_data,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int TGT_W  = $clog2(MAX_TARGETS);
    localparam int DIM_W  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int TA_W   = $clog2(MAX_TARGETS * MAX_DIMS);
    localparam int RAW_W  = (COMP_BITS > FIELD_COMP_W) ? COMP_BITS : FIELD_COMP_W;
    localparam int PROD_W = RATIO_W + DIST_W;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_RUN   = 5'b00010,
        S_DRAIN = 5'b00100,
        S_RATIO = 5'b01000,
        S_EMIT  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [TCOUNT_W-1:0] target_count_reg;
    logic [DIMS_W-1:0]   dims_in_use_reg;
    logic [RATIO_W-1:0]  ratio_squared_reg;

    logic [31:0]      nt_clamp;
    logic [31:0]      nd_clamp;
    logic [TGT_W-1:0] nt_last;
    logic [DIM_W-1:0] nd_last;

    logic                 in_xfer;
    logic                 search_start;
    logic [RAW_W-1:0]     comp_raw;
    logic [COMP_BITS-1:0] comp_bits;
    logic                 t_wr_en;
    logic [TA_W-1:0]      t_wr_addr;
    logic                 q_wr_en;
    logic [DIM_W-1:0]     q_wr_addr;

    logic [DIM_W-1:0] iss_dim_reg;
    logic [TGT_W-1:0] iss_tgt_reg;
    logic [TA_W-1:0]  iss_base_reg;
    logic             iss_last_dim;
    logic             iss_last_tgt;
    logic             rd_en;
    logic [TA_W-1:0]  t_rd_addr;

    logic                 v0_reg;
    mac_tag_t             tag0_reg;
    logic [COMP_BITS-1:0] q_rd_data;
    logic [COMP_BITS-1:0] t_rd_data;

    logic              dist_valid;
    logic [DIST_W-1:0] distance;
    logic [TGT_W-1:0]  cmp_tgt_reg;
    logic              cmp_done;

    logic [DIST_W-1:0] best_dist_reg;
    logic [DIST_W-1:0] second_dist_reg;
    logic [TGT_W-1:0]  best_slot_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [QID_W-1:0]  qid_reg;

    logic      out_free;
    logic      emit;
    logic      matched;
    logic      out_valid_reg;
    out_item_t out_data_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_count_reg  <= TARGET_COUNT_RST;
            dims_in_use_reg   <= DIMS_IN_USE_RST;
            ratio_squared_reg <= RATIO_SQUARED_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_TARGET_COUNT:  target_count_reg  <= cfg_data[TCOUNT_W-1:0];
                CFG_DIMS_IN_USE:   dims_in_use_reg   <= cfg_data[DIMS_W-1:0];
                CFG_RATIO_SQUARED: ratio_squared_reg <= cfg_data[RATIO_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        if (target_count_reg == '0)
        begin
            nt_clamp = 32'd1;
        end
        else if (32'(target_count_reg) > 32'(MAX_TARGETS))
        begin
            nt_clamp = 32'(MAX_TARGETS);
        end
        else
        begin
            nt_clamp = 32'(target_count_reg);
        end

        if (dims_in_use_reg == '0)
        begin
            nd_clamp = 32'd1;
        end
        else if (32'(dims_in_use_reg) > 32'(MAX_DIMS))
        begin
            nd_clamp = 32'(MAX_DIMS);
        end
        else
        begin
            nd_clamp = 32'(dims_in_use_reg);
        end
    end

    assign nt_last = TGT_W'(nt_clamp - 32'd1);
    assign nd_last = DIM_W'(nd_clamp - 32'd1);

    // input transfer and RAM writes
    assign in_stall     = (state_reg != S_IDLE);
    assign in_xfer      = in_valid && !in_stall;
    assign search_start = in_xfer && (in_data.action == ACT_QUERY) && in_data.last;

    assign comp_raw  = RAW_W'($unsigned(in_data.component));
    assign comp_bits = comp_raw[COMP_BITS-1:0];

    assign t_wr_en   = in_xfer && (in_data.action == ACT_LOAD)
                       && (32'(in_data.target_index) < 32'(MAX_TARGETS))
                       && (32'(in_data.dim_index) < 32'(MAX_DIMS));
    assign t_wr_addr = TA_W'(32'(in_data.target_index) * 32'(MAX_DIMS)
                             + 32'(in_data.dim_index));
    assign q_wr_en   = in_xfer && (in_data.action == ACT_QUERY)
                       && (32'(in_data.dim_index) < 32'(MAX_DIMS));
    assign q_wr_addr = DIM_W'(in_data.dim_index);

    // read issue
    assign rd_en        = (state_reg == S_RUN);
    assign iss_last_dim = (iss_dim_reg == nd_last);
    assign iss_last_tgt = (iss_tgt_reg == nt_last);
    assign t_rd_addr    = iss_base_reg + TA_W'(iss_dim_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iss_dim_reg  <= '0;
            iss_tgt_reg  <= '0;
            iss_base_reg <= '0;
            v0_reg       <= 1'b0;
        end
        else
        begin
            v0_reg <= rd_en;
            if (search_start)
            begin
                iss_dim_reg  <= '0;
                iss_tgt_reg  <= '0;
                iss_base_reg <= '0;
            end
            else if (rd_en)
            begin
                if (iss_last_dim)
                begin
                    iss_dim_reg  <= '0;
                    iss_tgt_reg  <= iss_tgt_reg + 1'b1;
                    iss_base_reg <= iss_base_reg + TA_W'(MAX_DIMS);
                end
                else
                begin
                    iss_dim_reg <= iss_dim_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tag0_reg.first <= (iss_dim_reg == '0);
        tag0_reg.last  <= iss_last_dim;
    end

    nnrm_ram #(
        .WIDTH (COMP_BITS),
        .DEPTH (MAX_TARGETS * MAX_DIMS)
    ) u_target_ram (
        .clk     (clk),
        .wr_en   (t_wr_en),
        .wr_addr (t_wr_addr),
        .wr_data (comp_bits),
        .rd_en   (rd_en),
        .rd_addr (t_rd_addr),
        .rd_data (t_rd_data)
    );

    nnrm_ram #(
        .WIDTH (COMP_BITS),
        .DEPTH (MAX_DIMS)
    ) u_query_ram (
        .clk     (clk),
        .wr_en   (q_wr_en),
        .wr_addr (q_wr_addr),
        .wr_data (comp_bits),
        .rd_en   (rd_en),
        .rd_addr (iss_dim_reg),
        .rd_data (q_rd_data)
    );

    nnrm_dist #(
        .COMP_BITS (COMP_BITS)
    ) u_dist (
        .clk         (clk),
        .rst_n       (rst_n),
        .mac_valid   (v0_reg),
        .mac_tag     (tag0_reg),
        .query_comp  (q_rd_data),
        .target_comp (t_rd_data),
        .dist_valid  (dist_valid),
        .distance    (distance)
    );

    // best and runner-up tracking
    assign cmp_done = dist_valid && (cmp_tgt_reg == nt_last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmp_tgt_reg <= '0;
        end
        else if (search_start)
        begin
            cmp_tgt_reg <= '0;
        end
        else if (dist_valid)
        begin
            cmp_tgt_reg <= cmp_tgt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (search_start)
        begin
            qid_reg <= in_data.query_id;
        end
        if (dist_valid)
        begin
            priority if (cmp_tgt_reg == '0)
            begin
                best_dist_reg   <= distance;
                second_dist_reg <= distance;
                best_slot_reg   <= '0;
            end
            else if (distance < best_dist_reg)
            begin
                second_dist_reg <= best_dist_reg;
                best_dist_reg   <= distance;
                best_slot_reg   <= cmp_tgt_reg;
            end
            else if (distance < second_dist_reg)
            begin
                second_dist_reg <= distance;
            end
        end
        if (state_reg == S_RATIO)
        begin
            prod_reg <= ratio_squared_reg * second_dist_reg;
        end
    end

    // sequencer
    assign out_free = !out_valid_reg || !out_stall;
    assign emit     = (state_reg == S_EMIT) && out_free;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (search_start)
                begin
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                if (iss_last_dim && iss_last_tgt)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (cmp_done)
                begin
                    state_next = S_RATIO;
                end
            end
            S_RATIO:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // output register
    assign matched = ({best_dist_reg, RATIO_SHIFT'(0)} < prod_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_data_reg.result_query_id    <= qid_reg;
            out_data_reg.matched            <= matched;
            out_data_reg.best_index         <= TIDX_W'(best_slot_reg);
            out_data_reg.nearest_distance   <= best_dist_reg;
            out_data_reg.runner_up_distance <= second_dist_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // checks
    a_dist_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        dist_valid |-> (state_reg == S_RUN || state_reg == S_DRAIN))
        else $error("distance completed outside a search");

    a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
        search_start |=> (state_reg == S_RUN))
        else $error("search did not start after last query transfer");

    a_best_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> (best_dist_reg <= second_dist_reg))
        else $error("best distance above runner-up");

    a_match_strict: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.matched)
            |-> (out_data.nearest_distance < out_data.runner_up_distance))
        else $error("match reported without a strictly nearer best");

    a_dim_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN) |-> (iss_dim_reg <= nd_last))
        else $error("dimension counter past dims in use");

endmodule
